FILE: hdl/asr_pkg.sv
// ----------------------------------------------------------------------------
// asr_pkg
// Types and constants for the annualized Sharpe ratio unit.
// ----------------------------------------------------------------------------
package asr_pkg;

  localparam int MAX_SAMPLES_DEF  = 4096;
  localparam int TRADING_DAYS_DEF = 252;

  localparam int SAMPLE_W = 24;
  localparam int CNT_W    = 13;
  localparam int SUM_W    = 36;
  localparam int SQ_W     = 60;
  localparam int VALUE_W  = 32;

  localparam int PROD_W    = 80;
  localparam int MPLIER_W  = 36;
  localparam int RAD_W     = 128;
  localparam int ROOT_W    = 64;
  localparam int SREM_W    = 68;
  localparam int NUM_W     = 47;
  localparam int NMAG_W    = 46;
  localparam int DIVD_W    = 86;
  localparam int DREM_W    = 66;
  localparam int STEP_W    = 7;

  localparam int MUL_STEPS  = 36;
  localparam int SQRT_STEPS = 64;
  localparam int DIV_STEPS  = 86;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_ZERO  = 2'd2;
  localparam logic [1:0] STATUS_SAT   = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] return_sample;
    logic                       has_sample;
    logic                       last;
  } asr_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sharpe_value;
    logic [1:0]                status;
  } asr_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL_NQ,
    ST_MUL_SS,
    ST_CHECK,
    ST_MUL_T,
    ST_NUM,
    ST_SQRT,
    ST_DIV,
    ST_FINISH
  } asr_state_t;

endpackage

FILE: hdl/annualized_sharpe_ratio_unit.sv
// ----------------------------------------------------------------------------
// annualized_sharpe_ratio_unit
// Accumulates daily returns and, at the last item of a series, forms the
// annualized Sharpe ratio with a bit-serial multiply, root and divide.
// ----------------------------------------------------------------------------
// items without last leave the unit idle; busy stays low
// a last item runs the shift-add multiplier passes, the one-bit-per-cycle
// root and the divider before the result
// an empty series goes from setup to finish; a zero-deviation one after the check
// the result strobe lasts one cycle; the receiver cannot stall
// synchronous reset clears the sequencer, accumulators and rate register
module annualized_sharpe_ratio_unit #(
  parameter int MAX_SAMPLES  = asr_pkg::MAX_SAMPLES_DEF,
  parameter int TRADING_DAYS = asr_pkg::TRADING_DAYS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  asr_pkg::asr_in_t             sample,
  input  logic                         cfg_we,
  input  logic [asr_pkg::SAMPLE_W-1:0] cfg_data,
  output logic                         done,
  output asr_pkg::asr_out_t            result
);
  import asr_pkg::*;

  asr_state_t state, state_next;

  logic signed [SAMPLE_W-1:0] rate;
  logic [CNT_W-1:0]           sample_count;
  logic signed [SUM_W-1:0]    return_sum;
  logic [SQ_W-1:0]            square_sum;

  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   mcand;
  logic [MPLIER_W-1:0] mplier;
  logic [PROD_W-1:0]   p1;
  logic [STEP_W-1:0]   step;

  logic [RAD_W-1:0]  x_sh;
  logic [SREM_W-1:0] srem;
  logic [ROOT_W-1:0] root;

  logic [DIVD_W-1:0] dv;
  logic [DIVD_W-1:0] quo;
  logic [DREM_W-1:0] drem;
  logic              num_neg;

  logic accept;
  logic take;
  logic signed [2*SAMPLE_W-1:0] sq;
  logic [SUM_W-1:0]    smag;
  logic [PROD_W-1:0]   dev;
  logic [SREM_W-1:0]   s_shift;
  logic [SREM_W-1:0]   s_trial;
  logic [DREM_W-1:0]   d_shift;
  logic [DREM_W-1:0]   d_div;
  logic signed [NUM_W-1:0] num;
  logic [NMAG_W-1:0]   nmag;
  logic [DIVD_W-1:0]   q_r;
  logic                last_step;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign take   = sample.has_sample && (sample_count < CNT_W'(MAX_SAMPLES));
  assign sq     = sample.return_sample * sample.return_sample;
  assign smag   = return_sum[SUM_W-1] ? SUM_W'(-return_sum) : SUM_W'(return_sum);
  assign dev    = p1 - acc;

  assign s_shift = {srem[SREM_W-3:0], x_sh[RAD_W-1 -: 2]};
  assign s_trial = SREM_W'({root, 2'b01});
  assign d_shift = {drem[DREM_W-2:0], dv[DIVD_W-1]};
  assign d_div   = DREM_W'(root);

  assign num = NUM_W'(return_sum * $signed({1'b0, 10'(TRADING_DAYS)}))
             - NUM_W'(rate * $signed({1'b0, sample_count}));
  assign nmag = num[NUM_W-1] ? NMAG_W'(-num) : NMAG_W'(num);
  assign q_r  = (drem >= (d_div - drem)) ? quo + DIVD_W'(1) : quo;

  always_comb begin
    unique case (state)
      ST_MUL_NQ, ST_MUL_SS, ST_MUL_T: last_step = (step == STEP_W'(MUL_STEPS - 1));
      ST_SQRT:                        last_step = (step == STEP_W'(SQRT_STEPS - 1));
      ST_DIV:                         last_step = (step == STEP_W'(DIV_STEPS - 1));
      default:                        last_step = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && sample.last) state_next = ST_SETUP;
      ST_SETUP:  state_next = (sample_count == '0) ? ST_FINISH : ST_MUL_NQ;
      ST_MUL_NQ: if (last_step) state_next = ST_MUL_SS;
      ST_MUL_SS: if (last_step) state_next = ST_CHECK;
      ST_CHECK:  state_next = (dev == '0) ? ST_FINISH : ST_MUL_T;
      ST_MUL_T:  if (last_step) state_next = ST_NUM;
      ST_NUM:    state_next = ST_SQRT;
      ST_SQRT:   if (last_step) state_next = ST_DIV;
      ST_DIV:    if (last_step) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // config and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      rate         <= '0;
      sample_count <= '0;
      return_sum   <= '0;
      square_sum   <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) rate <= cfg_data;
      if (accept && take) begin
        sample_count <= sample_count + CNT_W'(1);
        return_sum   <= return_sum + SUM_W'(sample.return_sample);
        square_sum   <= square_sum + SQ_W'(unsigned'(sq));
      end
      if (state == ST_FINISH) begin
        done         <= 1'b1;
        sample_count <= '0;
        return_sum   <= '0;
        square_sum   <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    step <= step + STEP_W'(1);
    unique case (state)
      ST_SETUP: begin
        result.sharpe_value <= '0;
        result.status       <= STATUS_EMPTY;
        acc    <= '0;
        mcand  <= PROD_W'(square_sum);
        mplier <= MPLIER_W'(sample_count);
        step   <= '0;
      end
      ST_MUL_NQ, ST_MUL_SS, ST_MUL_T: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= mplier >> 1;
        if (last_step && state == ST_MUL_NQ) begin
          p1     <= mplier[0] ? acc + mcand : acc;
          acc    <= '0;
          mcand  <= PROD_W'(smag);
          mplier <= MPLIER_W'(smag);
          step   <= '0;
        end
      end
      ST_CHECK: begin
        result.sharpe_value <= '0;
        result.status       <= STATUS_ZERO;
        acc    <= '0;
        mcand  <= dev;
        mplier <= MPLIER_W'(TRADING_DAYS);
        step   <= '0;
      end
      ST_NUM: begin
        x_sh    <= {acc, 48'b0};
        srem    <= '0;
        root    <= '0;
        num_neg <= num[NUM_W-1];
        dv      <= {nmag, 40'b0};
        step    <= '0;
      end
      ST_SQRT: begin
        x_sh <= {x_sh[RAD_W-3:0], 2'b00};
        if (s_shift >= s_trial) begin
          srem <= s_shift - s_trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          srem <= s_shift;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        if (last_step) begin
          drem <= '0;
          quo  <= '0;
          step <= '0;
        end
      end
      ST_DIV: begin
        dv <= {dv[DIVD_W-2:0], 1'b0};
        if (d_shift >= d_div) begin
          drem <= d_shift - d_div;
          quo  <= {quo[DIVD_W-2:0], 1'b1};
        end else begin
          drem <= d_shift;
          quo  <= {quo[DIVD_W-2:0], 1'b0};
        end
      end
      ST_FINISH: begin
        if (result.status == STATUS_OK) begin
          if (!num_neg) begin
            if (q_r > DIVD_W'(32'h7FFF_FFFF)) begin
              result.sharpe_value <= 32'sh7FFF_FFFF;
              result.status       <= STATUS_SAT;
            end else begin
              result.sharpe_value <= VALUE_W'(q_r);
            end
          end else begin
            if (q_r > DIVD_W'(32'h8000_0000)) begin
              result.sharpe_value <= 32'sh8000_0000;
              result.status       <= STATUS_SAT;
            end else begin
              result.sharpe_value <= VALUE_W'(-q_r);
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (state == ST_MUL_T && last_step) result.status <= STATUS_OK;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_plain_item: assert property (@(posedge clk) disable iff (rst)
    (accept && !sample.last) |=> !busy && !done)
    else $error("item without last started a series result");
  a_last_item: assert property (@(posedge clk) disable iff (rst)
    (accept && sample.last) |=> busy)
    else $error("last item did not start the final computation");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STATUS_EMPTY || result.status == STATUS_ZERO))
    |-> result.sharpe_value == '0)
    else $error("empty or flat series gave nonzero value");

endmodule

FILE: test/annualized_sharpe_ratio_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annualized_sharpe_ratio_unit_test
// Drives series of daily returns through the Sharpe ratio unit under several
// risk-free rates and idle patterns, predicts every ratio in exact integer
// arithmetic and checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module annualized_sharpe_ratio_unit_test;
  import asr_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  asr_in_t sample = '0;
  logic cfg_we = 1'b0;
  logic [SAMPLE_W-1:0] cfg_data = '0;
  logic done;
  asr_out_t result;

  annualized_sharpe_ratio_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .result(result)
  );

  always #1 clk = ~clk;

  asr_in_t pending_items[$];
  asr_out_t expected_ratios[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  logic taken = 1'b0;

  int unsigned day_count = 0;
  longint return_total = 0;
  logic [63:0] square_total = '0;
  longint risk_free = 0;

  task automatic queue_item(asr_in_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic logic [63:0] root128(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    int b;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  task automatic predict_ratio(asr_in_t it);
    longint x;
    logic [127:0] dev, rad, nw, q, rem;
    logic [63:0] smag, root;
    longint num;
    logic [63:0] nmag;
    asr_out_t o;
    x = longint'(it.return_sample);
    if (it.has_sample && day_count < MAX_SAMPLES_DEF) begin
      day_count++;
      return_total += x;
      square_total += 64'(x * x);
    end
    if (it.last) begin
      o = '0;
      if (day_count == 0) begin
        o.status = STATUS_EMPTY;
      end else begin
        smag = return_total < 0 ? 64'(-return_total) : 64'(return_total);
        dev = 128'(day_count) * {64'd0, square_total} - {64'd0, smag} * {64'd0, smag};
        if (dev == 0) begin
          o.status = STATUS_ZERO;
        end else begin
          rad = (dev * 128'(TRADING_DAYS_DEF)) << 48;
          root = root128(rad);
          num = return_total * TRADING_DAYS_DEF - risk_free * longint'(day_count);
          nmag = num < 0 ? 64'(-num) : 64'(num);
          nw = {64'd0, nmag} << 40;
          q = nw / {64'd0, root};
          rem = nw % {64'd0, root};
          if (rem >= {64'd0, root} - rem) q = q + 1;
          o.status = STATUS_OK;
          if (num >= 0) begin
            if (q > 128'h7FFFFFFF) begin
              o.sharpe_value = 32'h7FFFFFFF;
              o.status = STATUS_SAT;
            end else o.sharpe_value = q[31:0];
          end else begin
            if (q > 128'h80000000) begin
              o.sharpe_value = 32'h80000000;
              o.status = STATUS_SAT;
            end else o.sharpe_value = -q[31:0];
          end
        end
      end
      expected_ratios = {expected_ratios, o};
      day_count = 0;
      return_total = 0;
      square_total = '0;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    taken <= 1'b0;
    if (!rst && start && !busy) begin
      predict_ratio(sample);
      taken <= 1'b1;
    end
    if (!rst && done) begin
      if (expected_ratios.size() == 0) begin
        $error("unexpected result value %0d status %0d", result.sharpe_value, result.status);
        errors++;
      end else begin
        if (result.sharpe_value !== expected_ratios[0].sharpe_value) begin
          $error("sharpe_value expected %0d actual %0d",
                 expected_ratios[0].sharpe_value, result.sharpe_value);
          errors++;
        end
        if (result.status !== expected_ratios[0].status) begin
          $error("status expected %0d actual %0d", expected_ratios[0].status, result.status);
          errors++;
        end
        void'(expected_ratios.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && (!start || taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        sample <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        if ($urandom_range(1)) sample <= asr_in_t'($bits(asr_in_t)'($urandom));
      end
    end
  end

  function automatic asr_in_t day_item(int v, bit has, bit lst);
    asr_in_t it;
    it.return_sample = SAMPLE_W'(v);
    it.has_sample = has;
    it.last = lst;
    return it;
  endfunction

  task automatic add_series(int len);
    int base, spread, v, i;
    base = $urandom_range(1) ? int'($urandom) : $urandom_range(2000) - 1000;
    spread = 1 << $urandom_range(23);
    for (i = 0; i < len; i++) begin
      v = $urandom_range(9) == 0 ? int'($urandom) : base + int'($urandom_range(spread));
      if ($urandom_range(15) == 0) queue_item(day_item($urandom, 1'b0, 1'b0));
      queue_item(day_item(v, 1'b1, (i == len - 1) && $urandom_range(3) != 0));
    end
    if (!pending_items[$].last) queue_item(day_item($urandom, 1'b0, 1'b1));
  endtask

  task automatic drain_and_set(int rate);
    wait (pending_items.size() == 0 && !start && expected_ratios.size() == 0);
    repeat (400) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= rate[SAMPLE_W-1:0];
    risk_free = longint'($signed(rate[SAMPLE_W-1:0]));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int p, k;
    int rates[6];
    rates = '{0, -8388608, 8388607, 16384, -9000, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain_and_set(rates[0]);
    // empty, single, equal, extremes, mid-series gaps, a long series of extremes
    queue_item(day_item(0, 1'b0, 1'b1));
    queue_item(day_item(8388607, 1'b1, 1'b1));
    queue_item(day_item(-8388608, 1'b1, 1'b0));
    queue_item(day_item(-8388608, 1'b1, 1'b1));
    queue_item(day_item(8388607, 1'b1, 1'b0));
    queue_item(day_item(-8388608, 1'b1, 1'b1));
    queue_item(day_item(100000, 1'b1, 1'b0));
    queue_item(day_item(100001, 1'b1, 1'b1));
    queue_item(day_item(-100000, 1'b1, 1'b0));
    queue_item(day_item(-99999, 1'b1, 1'b0));
    queue_item(day_item(5, 1'b0, 1'b0));
    queue_item(day_item(0, 1'b0, 1'b1));
    queue_item(day_item(0, 1'b1, 1'b0));
    queue_item(day_item(65536, 1'b1, 1'b0));
    queue_item(day_item(-65536, 1'b1, 1'b1));
    for (k = 0; k < 100; k++)
      queue_item(day_item(k < 96 ? 8388607 - (k & 1) : -8388608, 1'b1, k == 99));
    for (p = 1; p < 6; p++) begin
      idle_pct = p <= 2 ? 22 : (p <= 4 ? 78 : 0);
      drain_and_set(p == 5 ? int'($urandom) : rates[p]);
      while (pending_items.size() < 200)
        add_series($urandom_range(7) == 0 ? $urandom_range(40, 1) : $urandom_range(8, 1));
    end
    wait (pending_items.size() == 0 && !start && expected_ratios.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_ratios.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
